// File: rtl/core/assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define IRA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`define IRA_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define IRA_ASSERT(label, clk, rst_n, prop)

`define IRA_NEVER(label, clk, rst_n, expr)

`endif

`endif

// File: rtl/core/ira_pkg.sv
`default_nettype none

package ira_pkg;

    // field widths of the channels
    localparam int VALUE_W = 31;
    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;
    localparam int DIGIT_W = 6;

    // storage sizing
    localparam int VALUE_BITS  = 31;
    localparam int DIGIT_SLOTS = 32;
    localparam int IDX_W = $clog2(DIGIT_SLOTS);
    localparam int CNT_W = $clog2(DIGIT_SLOTS + 1);
    localparam int BIT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    localparam logic [RADIX_W-1:0] RADIX_MIN      = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX      = RADIX_W'(36);
    localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = DIGIT_W'(10);
    localparam logic [CHAR_W-1:0]  ASCII_ZERO     = CHAR_W'(48);
    localparam logic [CHAR_W-1:0]  ASCII_A        = CHAR_W'(65);

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic store;
        logic emit_init;
        logic rd;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic bit_done;
        logic quot_zero;
        logic store_full;
        logic idx_zero;
        logic out_free;
    } t_status;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DECIMAL_DIGITS) begin
            c = ASCII_ZERO + CHAR_W'(d);
        end else begin
            c = ASCII_A + CHAR_W'(d - DECIMAL_DIGITS);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/ira_if.sv
`default_nettype none

interface ira_in_if;
    import ira_pkg::*;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

interface ira_out_if;
    import ira_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] digit_char;
    logic              last;

    modport source (output valid, output digit_char, output last, input ready);
    modport sink   (input valid, input digit_char, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ira_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module ira_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  ira_pkg::t_status  i_status,
    output ira_pkg::t_cmd     o_cmd
);
    import ira_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_STORE = 3'd2;
    localparam logic [2:0] S_INIT  = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_SEND  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.bit_done) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                // stop once the quotient is used up or the store is full
                if (i_status.quot_zero || i_status.store_full) begin
                    n_state = S_INIT;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_INIT: begin
                o_cmd.emit_init = 1'b1;
                n_state         = S_READ;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_SEND;
            end
            S_SEND: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = i_status.idx_zero ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `IRA_ASSERT(a_cmd_onehot, i_clk, i_rst_n, $onehot0(o_cmd))
    `IRA_ASSERT(a_load_when_free, i_clk, i_rst_n, o_cmd.out_load |-> i_status.out_free)

endmodule

`default_nettype wire

// File: rtl/core/ira_dpath.sv
`default_nettype none
`include "assert_macros.svh"

module ira_dpath (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire [ira_pkg::VALUE_W-1:0]   i_value,
    input  wire [ira_pkg::RADIX_W-1:0]   i_radix,
    input  ira_pkg::t_cmd                i_cmd,
    output ira_pkg::t_status             o_status,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [ira_pkg::CHAR_W-1:0]   o_digit_char,
    output logic                         o_last
);
    import ira_pkg::*;

    // ends of the two character runs
    localparam logic [CHAR_W-1:0] ASCII_NINE = CHAR_W'(57);
    localparam logic [CHAR_W-1:0] ASCII_Z    = CHAR_W'(90);

    logic [VALUE_BITS-1:0] r_quot, n_quot;
    logic [DIGIT_W-1:0]    r_rem, n_rem;
    logic [RADIX_W-1:0]    r_radix, n_radix;
    logic [BIT_W-1:0]      r_bit, n_bit;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic                  r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]     r_char;
    logic                  r_last;
    logic [DIGIT_W-1:0]    r_rd_data;
    logic [DIGIT_W-1:0]    r_mem [DIGIT_SLOTS];

    logic [DIGIT_W:0]      trial;
    logic [DIGIT_W:0]      diff;
    logic                  fits;

    // one restoring shift-subtract step, quotient bits shift in at the bottom
    assign trial = {r_rem, r_quot[VALUE_BITS-1]};
    assign diff  = trial - {1'b0, r_radix};
    assign fits  = (trial >= {1'b0, r_radix});

    always_comb begin
        n_quot      = r_quot;
        n_rem       = r_rem;
        n_radix     = r_radix;
        n_bit       = r_bit;
        n_count     = r_count;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (i_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.load) begin
            n_quot  = VALUE_BITS'(i_value);
            n_rem   = '0;
            n_bit   = '0;
            n_count = '0;
            if (i_radix < RADIX_MIN) begin
                n_radix = RADIX_MIN;
            end else if (i_radix > RADIX_MAX) begin
                n_radix = RADIX_MAX;
            end else begin
                n_radix = i_radix;
            end
        end
        if (i_cmd.div_step) begin
            n_quot = {r_quot[VALUE_BITS-2:0], fits};
            n_rem  = fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
            n_bit  = r_bit + BIT_W'(1);
        end
        if (i_cmd.store) begin
            n_rem   = '0;
            n_bit   = '0;
            n_count = r_count + CNT_W'(1);
        end
        if (i_cmd.emit_init) begin
            n_idx = IDX_W'(r_count - CNT_W'(1));
        end
        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
            n_idx       = r_idx - IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot  <= n_quot;
        r_rem   <= n_rem;
        r_radix <= n_radix;
        r_idx   <= n_idx;
        if (i_cmd.out_load) begin
            r_char <= digit_to_ascii(r_rd_data);
            r_last <= (r_idx == '0);
        end
    end

    // digit store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[r_count[IDX_W-1:0]] <= r_rem;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    assign o_status.bit_done   = (r_bit == BIT_W'(VALUE_BITS - 1));
    assign o_status.quot_zero  = (r_quot == '0);
    assign o_status.store_full = (r_count == CNT_W'(DIGIT_SLOTS - 1));
    assign o_status.idx_zero   = (r_idx == '0);
    assign o_status.out_free   = !r_out_valid || i_ready;

    assign o_valid      = r_out_valid;
    assign o_digit_char = r_char;
    assign o_last       = r_last;

    `IRA_ASSERT(a_rem_below_radix, i_clk, i_rst_n, i_cmd.div_step |-> (r_rem < r_radix))
    `IRA_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CNT_W'(DIGIT_SLOTS))
    `IRA_ASSERT(a_char_range, i_clk, i_rst_n, r_out_valid |-> (r_char >= ASCII_ZERO && r_char <= ASCII_Z))
    `IRA_NEVER(a_char_gap, i_clk, i_rst_n, r_out_valid && r_char > ASCII_NINE && r_char < ASCII_A)

endmodule

`default_nettype wire

// File: rtl/core/integer_to_radix_ascii.sv
`default_nettype none

// Converts a non-negative 31-bit integer into a string of ASCII digits in a
// radix from 2 to 36 (radix values outside that range clamp to the nearest
// end), streamed most significant digit first, '0'-'9' then 'A'-'Z', with
// last set on the final character; a zero value gives a single '0'. One
// conversion is in progress at a time. Each digit is the remainder of a
// 31-bit division in the shared shift-subtract divider, written to the digit
// store once all quotient bits are done, and each character is then read
// out through the store's registered read port. A new value is taken as
// soon as the last character sits in the output register.
module integer_to_radix_ascii (
    input  wire       i_clk,
    input  wire       i_rst_n,
    ira_in_if.sink    i_in,
    ira_out_if.source o_out
);
    import ira_pkg::*;

    t_cmd    cmd;
    t_status status;

    ira_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ira_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_value      (i_in.value),
        .i_radix      (i_in.radix),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_valid      (o_out.valid),
        .i_ready      (o_out.ready),
        .o_digit_char (o_out.digit_char),
        .o_last       (o_out.last)
    );

endmodule

`default_nettype wire

// File: bench/integer_to_radix_ascii_test.sv
`timescale 1ns / 1ps

module integer_to_radix_ascii_test;
    import ira_pkg::*;

    localparam int DRAIN_LIMIT = 40000;
    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ira_in_if  conv_in();
    ira_out_if char_out();

    integer_to_radix_ascii u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (conv_in),
        .o_out   (char_out)
    );

    char_t pending_chars[$];
    int    error_count = 0;
    bit    src_idle_en = 1'b1;
    bit    sink_idle_en = 1'b1;
    bit    sink_hold = 1'b0;
    int    stall_left = 0;

    always #4 i_clk = ~i_clk;

    // radix values outside two to thirty-six clamp to the nearest end
    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        if (r < RADIX_MIN) begin
            return RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            return RADIX_MAX;
        end
        return r;
    endfunction

    function automatic void predict_conversion(input logic [VALUE_W-1:0] value,
                                               input logic [RADIX_W-1:0] radix);
        logic [VALUE_W-1:0] quot;
        logic [VALUE_W-1:0] base;
        logic [DIGIT_W-1:0] digs [DIGIT_SLOTS];
        logic [DIGIT_W-1:0] d;
        char_t              c;
        int                 n;
        base = VALUE_W'(clamp_radix(radix));
        quot = value;
        n = 0;
        if (quot == '0) begin
            digs[0] = '0;
            n = 1;
        end else begin
            while (quot != '0 && n < DIGIT_SLOTS) begin
                digs[n] = DIGIT_W'(quot % base);
                quot = quot / base;
                n++;
            end
        end
        // digits were gathered least significant first
        for (int k = n - 1; k >= 0; k--) begin
            d = digs[k];
            if (d < DECIMAL_DIGITS) begin
                c.ch = ASCII_ZERO + CHAR_W'(d);
            end else begin
                c.ch = ASCII_A + CHAR_W'(d - DECIMAL_DIGITS);
            end
            c.last = (k == 0);
            pending_chars.push_back(c);
        end
    endfunction

    function automatic logic [RADIX_W-1:0] random_radix();
        if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 2) == 0) begin
                return RADIX_W'($urandom_range(0, 1));
            end
            return RADIX_W'($urandom_range(37, 63));
        end
        return RADIX_W'($urandom_range(2, 36));
    endfunction

    function automatic logic [VALUE_W-1:0] random_value(input logic [RADIX_W-1:0] radix);
        longint unsigned p;
        longint unsigned base;
        int              k;
        base = longint'(clamp_radix(radix));
        case ($urandom_range(0, 5))
            0: return VALUE_W'($urandom);
            1: return VALUE_W'($urandom_range(0, 100));
            2: begin
                // land on or just below a power of the radix
                p = 1;
                k = $urandom_range(1, 31);
                repeat (k) begin
                    if (p * base <= longint'(VALUE_MAX)) begin
                        p = p * base;
                    end
                end
                return VALUE_W'(p - longint'($urandom_range(0, 1)));
            end
            3: return VALUE_W'($urandom_range(0, 65536));
            4: return VALUE_MAX - VALUE_W'($urandom_range(0, 3));
            default: return VALUE_W'($urandom >> $urandom_range(1, 31));
        endcase
    endfunction

    // valid is left high after a transaction, the next call decides whether to drop it
    task automatic send_conversion(input logic [VALUE_W-1:0] value,
                                   input logic [RADIX_W-1:0] radix);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            conv_in.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        conv_in.valid <= 1'b1;
        conv_in.value <= value;
        conv_in.radix <= radix;
        do @(posedge i_clk); while (!conv_in.ready);
        predict_conversion(value, radix);
    endtask

    task automatic hold_sink(input int cycles);
        @(posedge i_clk);
        sink_hold <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        sink_hold <= 1'b0;
    endtask

    task automatic test_reset();
        conv_in.valid  = 1'b0;
        conv_in.value  = '0;
        conv_in.radix  = '0;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_conversion('0, RADIX_W'(10));
        send_conversion(VALUE_MAX, RADIX_W'(2));
        send_conversion(VALUE_MAX, RADIX_W'(36));
        send_conversion(VALUE_MAX, RADIX_W'(10));
        send_conversion(VALUE_W'(1), RADIX_W'(2));
        send_conversion(VALUE_W'(9), RADIX_W'(10));
        send_conversion(VALUE_W'(10), RADIX_W'(11));
        send_conversion(VALUE_W'(35), RADIX_W'(36));
        send_conversion(VALUE_W'(36), RADIX_W'(36));
        send_conversion(VALUE_W'(1) << (VALUE_W - 1), RADIX_W'(2));
        send_conversion(VALUE_W'(255), RADIX_W'(16));
        send_conversion(VALUE_W'(26), RADIX_W'(3));
        // out-of-range radix values
        send_conversion(VALUE_W'(12345), RADIX_W'(0));
        send_conversion(VALUE_W'(12345), RADIX_W'(1));
        send_conversion(VALUE_W'(12345), RADIX_W'(37));
        send_conversion(VALUE_MAX, {RADIX_W{1'b1}});
        send_conversion('0, {RADIX_W{1'b1}});
        send_conversion('0, RADIX_W'(0));
    endtask

    // stall the output long enough that the input backs up
    task automatic test_backpressure();
        src_idle_en = 1'b0;
        fork
            hold_sink(600);
            for (int i = 0; i < 12; i++) begin
                send_conversion(VALUE_W'($urandom_range(0, 5000)),
                                RADIX_W'($urandom_range(8, 36)));
            end
        join
        src_idle_en = 1'b1;
    endtask

    task automatic test_random();
        logic [RADIX_W-1:0] r;
        for (int i = 0; i < 400; i++) begin
            if (i % 50 == 0) begin
                src_idle_en = ($urandom_range(0, 3) != 0);
                sink_idle_en <= ($urandom_range(0, 3) != 0);
            end
            r = random_radix();
            send_conversion(random_value(r), r);
        end
    endtask

    task automatic test_no_idle();
        logic [RADIX_W-1:0] r;
        src_idle_en = 1'b0;
        sink_idle_en <= 1'b0;
        for (int i = 0; i < 40; i++) begin
            r = random_radix();
            send_conversion(random_value(r), r);
        end
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        @(posedge i_clk);
        conv_in.valid <= 1'b0;
        while (pending_chars.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_chars.size() != 0) begin
            $display("%0t: %0d characters never arrived", $time, pending_chars.size());
            error_count++;
        end
        repeat (64) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            char_out.ready <= 1'b0;
            stall_left <= 0;
        end else if (sink_hold) begin
            char_out.ready <= 1'b0;
        end else if (stall_left > 0) begin
            char_out.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
            // start a burst of idle cycles, its remaining length drawn into stall_left
            char_out.ready <= 1'b0;
            stall_left <= $urandom_range(0, 10);
        end else begin
            char_out.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        char_t seen;
        char_t want;
        if (i_rst_n && char_out.valid && char_out.ready) begin
            seen.ch   = char_out.digit_char;
            seen.last = char_out.last;
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual char %0d last %0b",
                         $time, seen.ch, seen.last);
                error_count++;
            end else begin
                want = pending_chars.pop_front();
                if (seen.ch !== want.ch) begin
                    $display("%0t: digit_char mismatch, expected %0d, actual %0d",
                             $time, want.ch, seen.ch);
                    error_count++;
                end
                if (seen.last !== want.last) begin
                    $display("%0t: last mismatch, expected %0b, actual %0b",
                             $time, want.last, seen.last);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #30ms;
        $display("%0t: timeout", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        test_reset();
        test_directed();
        test_backpressure();
        test_random();
        test_no_idle();
        drain();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
